[hw/rtl/imae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imae_pkg
// Shared types and constants of the integer matrix engine.
// ----------------------------------------------------------------------------
package imae_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_TRANS = 3'd4;

  localparam logic [2:0] REG_OP_MODE = 3'd0;
  localparam logic [2:0] REG_ROWS_A  = 3'd1;
  localparam logic [2:0] REG_COLS_A  = 3'd2;
  localparam logic [2:0] REG_COLS_B  = 3'd3;
  localparam logic [2:0] REG_SCALAR  = 3'd4;

  // control handed from the sequencer to the MAC cell chain
  typedef struct packed {
    logic       valid;  // a term enters the chain
    logic       first;  // clear the accumulator with this term
    logic       fin;    // accumulation finished after this term
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } mac_ctl_t;

endpackage

[hw/rtl/imae_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imae_cell
// One stage of the arithmetic chain: registers the control beat and the
// data handed from the previous stage.
// ----------------------------------------------------------------------------
module imae_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  imae_pkg::mac_ctl_t  ctl_in,
  input  logic [31:0]         data_in,
  output imae_pkg::mac_ctl_t  ctl_out,
  output logic [31:0]         data_out
);
  import imae_pkg::*;

  mac_ctl_t    ctl_r;
  logic [31:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
    data_r <= data_in;
  end

  assign ctl_out  = ctl_r;
  assign data_out = data_r;
endmodule

[hw/rtl/int_matrix_arith_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_matrix_arith_engine_core
// Integer matrix add, subtract, scale, multiply and transpose engine.
// ----------------------------------------------------------------------------
// Write op_mode and the dimensions on cfg_* while idle. Stream matrix A
// (in_operand_sel 0) and B (1) element beats row-major, one per cycle; the
// beat with in_load_last starts the pass for op_mode 0 to 4. in_ready is low during a pass.
// Results leave row-major on out_* with indices; out_result_last marks
// the final element. Each result term passes in order through the store
// read, the operand cell, the multiply cell and the accumulate cell of the
// single MAC chain; an element-wise pass feeds one term per result and a
// multiply feeds rows*cols_b*cols_a terms, cols_a per result.
// A stalled receiver holds the output register and freezes the chain.
// Reset clears counts, configuration registers and control; store contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
module int_matrix_arith_engine_core #(
  parameter int MAX_DIM = imae_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operand_sel,
  input  logic signed [31:0] in_elem_value,
  input  logic               in_load_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_result_row,
  output logic [2:0]         out_result_col,
  output logic               out_result_last
);
  import imae_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [2:0]  op_r;
  logic [3:0]  rows_r, cola_r, colb_r;
  logic [31:0] scal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_ADD; rows_r <= 4'd1; cola_r <= 4'd1; colb_r <= 4'd1;
      scal_r <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OP_MODE: op_r   <= cfg_data[2:0];
        REG_ROWS_A:  rows_r <= cfg_data[3:0];
        REG_COLS_A:  cola_r <= cfg_data[3:0];
        REG_COLS_B:  colb_r <= cfg_data[3:0];
        REG_SCALAR:  scal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [3:0] clampd(input logic [3:0] d);
    logic [3:0] m;
    m = 4'(MAX_DIM);
    if (d == 4'd0) return 4'd1;
    if (d > m) return m;
    return d;
  endfunction

  logic [3:0] nr, nc, ncb;
  assign nr  = clampd(rows_r);
  assign nc  = clampd(cola_r);
  assign ncb = clampd(colb_r);

  // stores
  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];
  logic [CW-1:0] cnt_a_r, cnt_b_r;

  logic busy_r;
  logic in_fire;
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;

  // sequencer: i outer, j middle, m inner
  logic [3:0] i_r, j_r, m_r;
  logic [3:0] lim_i, lim_j, lim_m;
  logic       is_mul, stall;

  assign is_mul = (op_r == OP_MUL);
  assign lim_i  = (op_r == OP_TRANS) ? nc : nr;
  assign lim_j  = (op_r == OP_TRANS) ? nr : (is_mul ? ncb : nc);
  assign lim_m  = is_mul ? nc : 4'd1;

  logic [6:0]  idx_a, idx_b;
  logic [31:0] rd_a_r, rd_b_r;
  mac_ctl_t    c0, c0_r;

  always_comb begin
    idx_a = 7'(i_r) * 7'(nc) + 7'(j_r);
    idx_b = idx_a;
    if (is_mul) begin
      idx_a = 7'(i_r) * 7'(nc) + 7'(m_r);
      idx_b = 7'(m_r) * 7'(ncb) + 7'(j_r);
    end else if (op_r == OP_TRANS) begin
      idx_a = 7'(j_r) * 7'(nc) + 7'(i_r);
    end
    c0.valid = busy_r;
    c0.first = (m_r == 4'd0);
    c0.fin   = (m_r + 4'd1 == lim_m);
    c0.row   = i_r[2:0];
    c0.col   = j_r[2:0];
    c0.last  = c0.fin && (i_r + 4'd1 == lim_i) && (j_r + 4'd1 == lim_j);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!in_operand_sel && cnt_a_r < CW'(DEPTH)) mem_a[cnt_a_r[AW-1:0]] <= in_elem_value;
      if (in_operand_sel && cnt_b_r < CW'(DEPTH))  mem_b[cnt_b_r[AW-1:0]] <= in_elem_value;
    end
    if (!stall) begin
      rd_a_r <= mem_a[idx_a[AW-1:0]];
      rd_b_r <= mem_b[idx_b[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0; cnt_b_r <= '0; busy_r <= 1'b0;
      i_r <= '0; j_r <= '0; m_r <= '0; c0_r <= '0;
    end else begin
      // advance the control beat in step with the store read
      if (!stall) c0_r <= c0;
      if (in_fire) begin
        if (in_load_last) begin
          cnt_a_r <= '0; cnt_b_r <= '0;
          busy_r  <= (op_r <= OP_TRANS);
          i_r <= '0; j_r <= '0; m_r <= '0;
        end else if (!in_operand_sel) begin
          if (cnt_a_r < CW'(DEPTH)) cnt_a_r <= cnt_a_r + CW'(1);
        end else if (cnt_b_r < CW'(DEPTH)) begin
          cnt_b_r <= cnt_b_r + CW'(1);
        end
      end else if (!stall) begin
        if (busy_r) begin
          if (!c0.fin) m_r <= m_r + 4'd1;
          else begin
            m_r <= '0;
            if (j_r + 4'd1 != lim_j) j_r <= j_r + 4'd1;
            else begin
              j_r <= '0;
              if (i_r + 4'd1 != lim_i) i_r <= i_r + 4'd1;
              else busy_r <= 1'b0;
            end
          end
        end
      end
    end
  end

  // operand cell: pick the operand pair for the op
  logic [31:0] opa, opb, pre;
  always_comb begin
    opa = rd_a_r; opb = rd_b_r; pre = 32'd0;
    case (op_r)
      OP_ADD:   pre = rd_a_r + rd_b_r;
      OP_SUB:   pre = rd_a_r - rd_b_r;
      OP_SCALE: opb = scal_r;
      OP_MUL:   ;
      default:  opb = 32'd1;
    endcase
  end

  mac_ctl_t    c1, c2, c3;
  logic [31:0] d1, d2, d3;
  logic [31:0] prod, acc_in;
  logic        ew_r;

  // pass-through data for add and subtract rides beside the product
  logic [31:0] pre_r, opb_r, opa_r;
  always_ff @(posedge clk) begin
    if (!stall) begin
      pre_r <= pre; opa_r <= opa; opb_r <= opb;
      ew_r  <= (op_r == OP_ADD) || (op_r == OP_SUB);
    end
  end

  logic frz_rst;
  assign frz_rst = rst_n;

  // stage 1: operand registers -> product
  imae_cell u_c1 (.clk(clk), .rst_n(frz_rst),
    .ctl_in(stall ? c1 : c0_r), .data_in(stall ? d1 : 32'd0),
    .ctl_out(c1), .data_out(d1));
  assign prod = ew_r ? pre_r : opa_r * opb_r;

  // stage 2: product registered
  imae_cell u_c2 (.clk(clk), .rst_n(frz_rst),
    .ctl_in(stall ? c2 : c1), .data_in(stall ? d2 : prod),
    .ctl_out(c2), .data_out(d2));

  // stage 3: accumulate
  assign acc_in = c2.first ? d2 : d3 + d2;
  imae_cell u_c3 (.clk(clk), .rst_n(frz_rst),
    .ctl_in(stall ? c3 : (c2.valid ? c2 : '0)), .data_in(stall ? d3 : (c2.valid ? acc_in : d3)),
    .ctl_out(c3), .data_out(d3));

  // operand regs must advance in step with c1: hold them on stall
  // (pre_r/opa_r/opb_r load with c0_r->c1 since both gate on !stall)

  // output register
  logic        ov_r;
  logic [31:0] ovl_r;
  logic [2:0]  orw_r, ocl_r;
  logic        olst_r;
  assign stall = ov_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!stall) begin
      ov_r <= c3.valid && c3.fin;
    end
    if (!stall) begin
      ovl_r <= d3; orw_r <= c3.row; ocl_r <= c3.col; olst_r <= c3.last;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_value = ovl_r;
  assign out_result_row   = orw_r;
  assign out_result_col   = ocl_r;
  assign out_result_last  = olst_r;

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("load accepted during pass");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_value)))
    else $error("result dropped under stall");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_result_last) |=> !busy_r)
    else $error("last result while pass still running");
endmodule

[bench/imae_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imae_checker
// Watches the configuration port and both streams of the matrix engine,
// keeps its own copy of the operand stores and registers, works out every
// result matrix when the closing load beat is accepted, and compares each
// result beat field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module imae_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operand_sel,
  input  logic signed [31:0] in_elem_value,
  input  logic               in_load_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result_value,
  input  logic [2:0]         out_result_row,
  input  logic [2:0]         out_result_col,
  input  logic               out_result_last,
  output int                 fail_count,
  output int                 pending
);
  import imae_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  row;
    logic [2:0]  col;
    logic        last;
  } elem_res_t;

  localparam int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF;

  logic [31:0] a_mem [DEPTH];
  logic [31:0] b_mem [DEPTH];
  int unsigned a_cnt, b_cnt;
  logic [2:0]  mode_r;
  logic [3:0]  rows_r, cols_r, colsb_r;
  logic [31:0] scalar_r;
  elem_res_t   expected_q[$];

  assign pending = expected_q.size();

  function automatic int unsigned eff_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic void push_res(logic [31:0] v, int unsigned r, int unsigned c, logic l);
    elem_res_t e;
    e.value = v;
    e.row   = r[2:0];
    e.col   = c[2:0];
    e.last  = l;
    expected_q.push_back(e);
  endfunction

  // work out the whole result matrix of one pass
  task automatic compute_matrix();
    int unsigned nr, nc, ncb;
    logic [31:0] acc, av, bv;
    nr  = eff_dim(rows_r);
    nc  = eff_dim(cols_r);
    ncb = eff_dim(colsb_r);
    case (mode_r)
      OP_ADD, OP_SUB, OP_SCALE: begin
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < nc; j++) begin
            av = a_mem[i*nc+j];
            bv = b_mem[i*nc+j];
            if (mode_r == OP_ADD) acc = av + bv;
            else if (mode_r == OP_SUB) acc = av - bv;
            else acc = av * scalar_r;
            push_res(acc, i, j, (i == nr-1) && (j == nc-1));
          end
      end
      OP_MUL: begin
        for (int i = 0; i < nr; i++)
          for (int j = 0; j < ncb; j++) begin
            acc = '0;
            for (int m = 0; m < nc; m++) acc += a_mem[i*nc+m] * b_mem[m*ncb+j];
            push_res(acc, i, j, (i == nr-1) && (j == ncb-1));
          end
      end
      OP_TRANS: begin
        for (int i = 0; i < nc; i++)
          for (int j = 0; j < nr; j++)
            push_res(a_mem[j*nc+i], i, j, (i == nc-1) && (j == nr-1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    elem_res_t e;
    if (!rst_n) begin
      a_cnt <= 0;
      b_cnt <= 0;
      mode_r <= OP_ADD;
      rows_r <= 4'd1;
      cols_r <= 4'd1;
      colsb_r <= 4'd1;
      scalar_r <= 32'd1;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OP_MODE: mode_r   <= cfg_data[2:0];
          REG_ROWS_A:  rows_r   <= cfg_data[3:0];
          REG_COLS_A:  cols_r   <= cfg_data[3:0];
          REG_COLS_B:  colsb_r  <= cfg_data[3:0];
          REG_SCALAR:  scalar_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        // store the beat first, the closing beat then starts the pass
        if (!in_operand_sel) begin
          if (a_cnt < DEPTH) begin
            a_mem[a_cnt] = in_elem_value;
            a_cnt = a_cnt + 1;
          end
        end else if (b_cnt < DEPTH) begin
          b_mem[b_cnt] = in_elem_value;
          b_cnt = b_cnt + 1;
        end
        if (in_load_last) begin
          compute_matrix();
          a_cnt = 0;
          b_cnt = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing outstanding: value %0d row %0d col %0d",
                 out_result_value, out_result_row, out_result_col);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_result_value !== e.value || out_result_row !== e.row ||
              out_result_col !== e.col || out_result_last !== e.last) begin
            if (out_result_value !== e.value)
              $error("result_value expected %0d got %0d", $signed(e.value), out_result_value);
            if (out_result_row !== e.row)
              $error("result_row expected %0d got %0d", e.row, out_result_row);
            if (out_result_col !== e.col)
              $error("result_col expected %0d got %0d", e.col, out_result_col);
            if (out_result_last !== e.last)
              $error("result_last expected %0d got %0d", e.last, out_result_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[bench/tb_int_matrix_arith_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_matrix_arith_engine_core
// Drives the matrix engine with directed then random load sequences over
// changing shapes and operations, with random gaps and output stalls; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_int_matrix_arith_engine_core;
  import imae_pkg::*;

  localparam int DEPTH       = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LOAD_TARGET = 450;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_ready, in_operand_sel, in_load_last;
  logic signed [31:0] in_elem_value;
  logic               out_valid, out_ready, out_result_last;
  logic signed [31:0] out_result_value;
  logic [2:0]         out_result_row, out_result_col;
  int                 fail_count, pending;
  int unsigned        cycle_cnt = 0;

  // stimulus-side copy of the shape, needed to plan legal loads
  logic [2:0]  cur_mode = OP_ADD;
  logic [3:0]  cur_rows = 4'd1, cur_cols = 4'd1, cur_colsb = 4'd1;
  int unsigned a_written = 0, b_written = 0;
  int unsigned loads_sent = 0;
  bit          calm = 1'b0;
  bit          extreme_vals = 1'b0;

  always #5 clk = ~clk;

  int_matrix_arith_engine_core dut (.*);

  imae_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned gap_draw();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic int unsigned eff_dim(logic [3:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return d;
  endfunction

  function automatic logic [31:0] elem_draw();
    case ($urandom_range(0, extreme_vals ? 3 : 15))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5, 6: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // receiver: draw a stall per result beat
  initial begin
    int unsigned stall;
    bit took;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = gap_draw();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk) took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic cfg_put(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_OP_MODE: cur_mode  = data[2:0];
      REG_ROWS_A:  cur_rows  = data[3:0];
      REG_COLS_A:  cur_cols  = data[3:0];
      REG_COLS_B:  cur_colsb = data[3:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a pass with no results may still be finishing
    repeat (8) @(posedge clk);
  endtask

  task automatic load_beat(logic sel, logic [31:0] v, logic last);
    int unsigned gap;
    bit took;
    gap = gap_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operand_sel <= sel;
    in_elem_value  <= v;
    in_load_last   <= last;
    do begin
      @(negedge clk) took = in_ready;
      @(posedge clk);
    end while (!took);
    loads_sent++;
  endtask

  // one pass: loads of A and B interleaved at random, closing beat last
  task automatic run_pass(int na, int nb);
    int ra, rb;
    logic sel;
    if (na + nb == 0) na = 1;
    ra = na;
    rb = nb;
    while (ra + rb > 0) begin
      sel = (ra == 0) ? 1'b1 : (rb == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      if (sel) rb--; else ra--;
      load_beat(sel, elem_draw(), (ra + rb) == 0);
    end
    if (na > a_written) a_written = (na > DEPTH) ? DEPTH : na;
    if (nb > b_written) b_written = (nb > DEPTH) ? DEPTH : nb;
  endtask

  // plan counts from the shape, keeping every read on a written entry
  task automatic random_pass();
    int unsigned nr, nc, ncb, need_a, need_b;
    int na, nb;
    nr = eff_dim(cur_rows);
    nc = eff_dim(cur_cols);
    ncb = eff_dim(cur_colsb);
    need_a = (cur_mode <= OP_TRANS) ? nr * nc : 0;
    case (cur_mode)
      OP_ADD, OP_SUB: need_b = nr * nc;
      OP_MUL:         need_b = nc * ncb;
      default:        need_b = 0;
    endcase
    na = need_a;
    nb = need_b;
    if (a_written >= need_a && $urandom_range(0, 6) == 0) na = $urandom_range(0, need_a);
    if (b_written >= need_b && $urandom_range(0, 6) == 0) nb = $urandom_range(0, need_b);
    if (need_b == 0 && $urandom_range(0, 3) == 0) nb = $urandom_range(1, 4);
    if ($urandom_range(0, 24) == 0) na = DEPTH + $urandom_range(1, 3);
    if ($urandom_range(0, 24) == 0) nb = DEPTH + $urandom_range(1, 3);
    run_pass(na, nb);
  endtask

  function automatic logic [3:0] dim_draw();
    case ($urandom_range(0, 19))
      0: return 4'd0;
      1: return 4'($urandom_range(MAX_DIM_DEF + 1, 15));
      2, 3: return 4'(MAX_DIM_DEF);
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic random_config();
    logic [2:0] m;
    m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 1)) cfg_put(REG_OP_MODE, {29'($urandom), m});
    if ($urandom_range(0, 1)) cfg_put(REG_ROWS_A, {28'($urandom), dim_draw()});
    if ($urandom_range(0, 1)) cfg_put(REG_COLS_A, {28'($urandom), dim_draw()});
    if ($urandom_range(0, 1)) cfg_put(REG_COLS_B, {28'($urandom), dim_draw()});
    if ($urandom_range(0, 2) == 0) cfg_put(REG_SCALAR, elem_draw());
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(logic [2:0] m, logic [3:0] r, logic [3:0] c, logic [3:0] cb);
    cfg_put(REG_OP_MODE, {29'd0, m});
    cfg_put(REG_ROWS_A, {28'd0, r});
    cfg_put(REG_COLS_A, {28'd0, c});
    cfg_put(REG_COLS_B, {28'd0, cb});
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_OP_MODE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_operand_sel <= 1'b0;
    in_elem_value  <= '0;
    in_load_last   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme values through every operation
    extreme_vals = 1'b1;
    set_shape(OP_ADD, 4'd1, 4'd2, 4'd1);
    run_pass(2, 2);
    wait_idle();
    set_shape(OP_SUB, 4'd2, 4'd1, 4'd1);
    run_pass(2, 2);
    wait_idle();
    cfg_put(REG_SCALAR, 32'h8000_0000);
    set_shape(OP_SCALE, 4'd0, 4'd2, 4'd1);
    run_pass(2, 0);
    wait_idle();
    cfg_put(REG_SCALAR, 32'h7fff_ffff);
    cfg_we <= 1'b0;
    run_pass(1, 0);
    wait_idle();
    set_shape(OP_MUL, 4'd1, 4'd2, 4'd2);
    run_pass(2, 4);
    wait_idle();
    set_shape(OP_TRANS, 4'd2, 4'd15, 4'd1);
    run_pass(16, 0);
    wait_idle();
    set_shape(3'd7, 4'd1, 4'd1, 4'd1);
    run_pass(1, 1);
    wait_idle();
    extreme_vals = 1'b0;

    while (loads_sent < LOAD_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      random_config();
      random_pass();
      wait_idle();
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
